@@ src/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ src/plob_pkg.sv @@
// package for the price level order book
// types, sizes and action codes; no dependencies
package plob_pkg;
    localparam int LEVELS = 32;
    localparam int MAXOUT = 32;
    localparam int IDX_W = $clog2(LEVELS);
    localparam int CNT_W = $clog2(LEVELS + 1);
    localparam int ENT_W = 80;

    typedef enum logic [2:0] {
        ACT_NEW = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_SNAPSHOT = 3'd4,
        ACT_READ = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT_UP,
        ST_SHIFT_DOWN,
        ST_READ,
        ST_DONE
    } state_t;
endpackage

@@ src/price_level_order_book_top.sv @@
// price level order book: one memory per side, sequencer walks levels
// depends on plob_pkg and assert_macros.svh
// search reads one level per cycle up to the key or its slot, a shift moves one
// entry per cycle; busy stays high until the last result is strobed.
// a read emits one level per cycle, each from a registered memory read.
// results are strobed for one cycle, the receiver cannot stall; reset empties both books.
`include "assert_macros.svh"
module price_level_order_book_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic        side,
    input  logic [31:0] price,
    input  logic [31:0] quantity,
    input  logic [15:0] order_count,
    input  logic [5:0]  depth,
    output logic        result_valid,
    output logic        best_bid_valid,
    output logic [31:0] best_bid_price,
    output logic [31:0] best_bid_qty,
    output logic        best_ask_valid,
    output logic [31:0] best_ask_price,
    output logic [31:0] best_ask_qty,
    output logic        level_valid,
    output logic [31:0] level_price,
    output logic [31:0] level_qty,
    output logic [15:0] level_orders,
    output logic        last_level,
    output logic        side_full
);
    localparam int IW = plob_pkg::IDX_W;
    localparam int CW = plob_pkg::CNT_W;

    // entry = {price, qty, orders}
    logic [plob_pkg::ENT_W-1:0] bid_mem [plob_pkg::LEVELS];
    logic [plob_pkg::ENT_W-1:0] ask_mem [plob_pkg::LEVELS];
    logic [plob_pkg::ENT_W-1:0] rd_data;

    plob_pkg::state_t state_reg, state_next;
    logic [CW-1:0] bid_cnt_reg, bid_cnt_next, ask_cnt_reg, ask_cnt_next;
    logic [CW-1:0] ptr_reg, ptr_next, lim_reg, lim_next;
    logic          side_reg, full_reg, full_next;
    logic [31:0]   pr_reg, qty_reg;
    logic [15:0]   ord_reg;
    logic          del_reg;
    logic [63:0]   bid_top_reg, bid_top_next, ask_top_reg, ask_top_next;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [plob_pkg::ENT_W-1:0] wr_data;
    logic          rd_pend_reg;
    logic [CW-1:0] cnt_cur;
    logic [31:0]   rd_price;
    logic          hit, past;
    logic          emit;
    logic [CW-1:0] rd_lim;
    logic [CW-1:0] side_cnt_in;

    assign cnt_cur = side_reg ? bid_cnt_reg : ask_cnt_reg;
    assign rd_price = rd_data[79:48];
    assign hit = rd_price == pr_reg;
    assign past = side_reg ? (rd_price < pr_reg) : (rd_price > pr_reg);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= side_reg ? bid_mem[rd_addr] : ask_mem[rd_addr];
        end
        if (wr_en && side_reg)
        begin
            bid_mem[wr_addr] <= wr_data;
        end
        if (wr_en && !side_reg)
        begin
            ask_mem[wr_addr] <= wr_data;
        end
    end

    // read limit on entering read
    always_comb
    begin
        side_cnt_in = side ? bid_cnt_reg : ask_cnt_reg;
        rd_lim = (depth < 6'(side_cnt_in)) ? CW'(depth) : side_cnt_in;
        if (rd_lim > CW'(plob_pkg::MAXOUT)) rd_lim = CW'(plob_pkg::MAXOUT);
    end

    // next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        lim_next = lim_reg;
        full_next = full_reg;
        bid_cnt_next = bid_cnt_reg;
        ask_cnt_next = ask_cnt_reg;
        bid_top_next = bid_top_reg;
        ask_top_next = ask_top_reg;
        rd_en = 1'b0;
        rd_addr = ptr_reg[IW-1:0];
        wr_en = 1'b0;
        wr_addr = ptr_reg[IW-1:0];
        wr_data = {pr_reg, qty_reg, ord_reg};
        emit = 1'b0;
        case (state_reg)
            plob_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ptr_next = '0;
                    full_next = 1'b0;
                    state_next = plob_pkg::ST_DONE;
                    case (plob_pkg::action_t'(action))
                        plob_pkg::ACT_NEW, plob_pkg::ACT_UPDATE, plob_pkg::ACT_DELETE,
                        plob_pkg::ACT_SNAPSHOT:
                        begin
                            state_next = plob_pkg::ST_SEARCH;
                        end
                        plob_pkg::ACT_CLEAR:
                        begin
                            bid_cnt_next = '0;
                            ask_cnt_next = '0;
                        end
                        plob_pkg::ACT_READ:
                        begin
                            lim_next = rd_lim;
                            state_next = plob_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = plob_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            plob_pkg::ST_SEARCH:
            begin
                // rd_data holds entry ptr-1 when rd_pend_reg
                if (rd_pend_reg && (hit || (past && !del_reg)))
                begin
                    if (hit && del_reg)
                    begin
                        ptr_next = ptr_reg;
                        state_next = plob_pkg::ST_SHIFT_DOWN;
                        rd_en = ptr_reg < cnt_cur;
                    end
                    else if (hit)
                    begin
                        wr_en = 1'b1;
                        wr_addr = IW'(ptr_reg - 1'b1);
                        state_next = plob_pkg::ST_DONE;
                    end
                    else if (cnt_cur == CW'(plob_pkg::LEVELS))
                    begin
                        full_next = 1'b1;
                        state_next = plob_pkg::ST_DONE;
                    end
                    else
                    begin
                        // no need to check the rest for a hit: prices are sorted, so none further
                        lim_next = ptr_reg - 1'b1;
                        ptr_next = cnt_cur;
                        state_next = plob_pkg::ST_SHIFT_UP;
                        rd_en = cnt_cur != '0;
                        rd_addr = IW'(cnt_cur - 1'b1);
                    end
                end
                else if (ptr_reg < cnt_cur)
                begin
                    rd_en = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (del_reg)
                begin
                    state_next = plob_pkg::ST_DONE;
                end
                else if (cnt_cur == CW'(plob_pkg::LEVELS))
                begin
                    full_next = 1'b1;
                    state_next = plob_pkg::ST_DONE;
                end
                else
                begin
                    lim_next = cnt_cur;
                    ptr_next = cnt_cur;
                    state_next = plob_pkg::ST_SHIFT_UP;
                    rd_en = 1'b0;
                end
            end
            plob_pkg::ST_SHIFT_UP:
            begin
                // ptr is destination; rd_data holds entry ptr-1
                if (ptr_reg == lim_reg)
                begin
                    wr_en = 1'b1;
                    if (side_reg) bid_cnt_next = bid_cnt_reg + 1'b1;
                    else ask_cnt_next = ask_cnt_reg + 1'b1;
                    state_next = plob_pkg::ST_DONE;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_data = rd_data;
                    ptr_next = ptr_reg - 1'b1;
                    rd_en = (ptr_reg - 1'b1) != lim_reg;
                    rd_addr = IW'(ptr_reg - 2'd2);
                end
            end
            plob_pkg::ST_SHIFT_DOWN:
            begin
                // rd_data holds entry ptr, goes to ptr-1
                if (ptr_reg < cnt_cur)
                begin
                    wr_en = 1'b1;
                    wr_addr = IW'(ptr_reg - 1'b1);
                    wr_data = rd_data;
                    ptr_next = ptr_reg + 1'b1;
                    rd_en = (ptr_reg + 1'b1) < cnt_cur;
                    rd_addr = IW'(ptr_reg + 1'b1);
                end
                else
                begin
                    if (side_reg) bid_cnt_next = bid_cnt_reg - 1'b1;
                    else ask_cnt_next = ask_cnt_reg - 1'b1;
                    state_next = plob_pkg::ST_DONE;
                end
            end
            plob_pkg::ST_READ:
            begin
                if (rd_pend_reg)
                begin
                    emit = 1'b1;
                end
                if (ptr_reg < lim_reg)
                begin
                    rd_en = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (lim_reg == '0)
                begin
                    state_next = plob_pkg::ST_DONE;
                end
                else
                begin
                    state_next = plob_pkg::ST_IDLE;
                end
            end
            plob_pkg::ST_DONE:
            begin
                state_next = plob_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = plob_pkg::ST_IDLE;
            end
        endcase
        // keep top-of-book copies coherent with entry 0 writes
        if (wr_en && wr_addr == '0)
        begin
            if (side_reg) bid_top_next = wr_data[79:16];
            else ask_top_next = wr_data[79:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plob_pkg::ST_IDLE;
            bid_cnt_reg <= '0;
            ask_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bid_cnt_reg <= bid_cnt_next;
            ask_cnt_reg <= ask_cnt_next;
            rd_pend_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        lim_reg <= lim_next;
        full_reg <= full_next;
        bid_top_reg <= bid_top_next;
        ask_top_reg <= ask_top_next;
        if (state_reg == plob_pkg::ST_IDLE && start)
        begin
            side_reg <= side;
            pr_reg <= price;
            qty_reg <= quantity;
            ord_reg <= (action == plob_pkg::ACT_SNAPSHOT) ? order_count : 16'd1;
            del_reg <= (action == plob_pkg::ACT_DELETE) ||
                       ((action == plob_pkg::ACT_NEW || action == plob_pkg::ACT_UPDATE)
                        && quantity == 32'd0);
        end
    end

    // shift-down of entry 1 into 0 also updates the top-of-book copy
    assign busy = state_reg != plob_pkg::ST_IDLE;
    assign result_valid = emit || state_reg == plob_pkg::ST_DONE;
    assign best_bid_valid = bid_cnt_reg != '0;
    assign best_bid_price = best_bid_valid ? bid_top_reg[63:32] : 32'd0;
    assign best_bid_qty = best_bid_valid ? bid_top_reg[31:0] : 32'd0;
    assign best_ask_valid = ask_cnt_reg != '0;
    assign best_ask_price = best_ask_valid ? ask_top_reg[63:32] : 32'd0;
    assign best_ask_qty = best_ask_valid ? ask_top_reg[31:0] : 32'd0;
    assign level_valid = emit;
    assign level_price = emit ? rd_data[79:48] : 32'd0;
    assign level_qty = emit ? rd_data[47:16] : 32'd0;
    assign level_orders = emit ? rd_data[15:0] : 16'd0;
    assign last_level = state_reg == plob_pkg::ST_DONE || (emit && ptr_reg == lim_reg);
    assign side_full = state_reg == plob_pkg::ST_DONE && full_reg;

    `ASSERT_IMP(a_no_start_busy, clk, rst_n, result_valid && !emit, busy)
    `ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1,
        bid_cnt_reg <= CW'(plob_pkg::LEVELS) && ask_cnt_reg <= CW'(plob_pkg::LEVELS))
    `ASSERT_NEXT(a_done_idle, clk, rst_n, state_reg == plob_pkg::ST_DONE,
        state_reg == plob_pkg::ST_IDLE)
endmodule
